// ===== rtl/wmv_pkg.sv =====
// shared types and constants for the weighted mean and variance block
`timescale 1ns / 1ps
`default_nettype none

package wmv_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int WEIGHT_W  = 8;
	localparam int SUM_W     = 36;
	localparam int SQ_W      = 50;
	localparam int TW_W      = 20;
	localparam int PROD_W    = SAMPLE_W + WEIGHT_W + 1;
	localparam int SQR_W     = 2 * SAMPLE_W - 1;
	localparam int SQW_W     = SQR_W + WEIGHT_W;
	localparam int MEAN_W    = 16;
	localparam int VAR_W     = 31;
	localparam int MM_W      = 2 * MEAN_W;
	localparam int CNT_W     = 6;
	localparam int MEAN_STEPS = SUM_W;
	localparam int SQ_STEPS   = SQ_W;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [VAR_W-1:0] VAR_MAX = VAR_W'(1) << 30;

	// accumulated sums of one finished set
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sq;
		logic [TW_W-1:0]         tw;
	} set_sums_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/wmv_if.sv =====
// handshake channels for samples and results
`timescale 1ns / 1ps
`default_nettype none

interface wmv_in_if;
	import wmv_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [WEIGHT_W-1:0]        weight;
	logic                       last;

	modport source (output valid, output sample, output weight, output last, input ready);
	modport sink (input valid, input sample, input weight, input last, output ready);
endinterface

interface wmv_out_if;
	import wmv_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [MEAN_W-1:0] mean;
	logic [VAR_W-1:0]         variance;
	logic                     zero_weight;

	modport source (output valid, output mean, output variance, output zero_weight, input ready);
	modport sink (input valid, input mean, input variance, input zero_weight, output ready);
endinterface

`default_nettype wire

// ===== rtl/wmv_front.sv =====
// front end: takes samples, forms products and accumulates each set
`timescale 1ns / 1ps
`default_nettype none

module wmv_front
	import wmv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	wmv_in_if.sink      samples,
	input  wire q_stat_t q_stat,
	output logic        push,
	output set_sums_t   push_data
);

	logic weighted_q;
	logic adv;
	logic accepted;

	logic v_s1, v_s2, v_s3;
	logic last_s1, last_s2, last_s3;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [WEIGHT_W-1:0] w_s1, w_s2, w_s3;
	logic signed [PROD_W-1:0] prod_s2, prod_s3;
	logic [SQR_W-1:0] sq_s2;
	logic [SQW_W-1:0] sqw_s3;
	logic signed [2*SAMPLE_W-1:0] sq_full;

	logic signed [SUM_W-1:0] acc_sum_q;
	logic [SQ_W-1:0] acc_sq_q;
	logic [TW_W-1:0] acc_tw_q;
	set_sums_t sums_next;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q <= 1'b0;
		end else if (cfg_we) begin
			weighted_q <= cfg_wdata;
		end
	end

	// whole pipeline holds while a finished set waits for queue space
	assign adv = !(v_s3 && last_s3 && q_stat.full);
	assign samples.ready = adv;
	assign accepted = samples.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accepted;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sq_full = sample_s1 * sample_s1;

	// product stages
	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= samples.sample;
			w_s1      <= weighted_q ? samples.weight : WEIGHT_W'(1);
			last_s1   <= samples.last;

			prod_s2 <= sample_s1 * $signed({1'b0, w_s1});
			sq_s2   <= sq_full[SQR_W-1:0];
			w_s2    <= w_s1;
			last_s2 <= last_s1;

			prod_s3 <= prod_s2;
			sqw_s3  <= sq_s2 * w_s2;
			w_s3    <= w_s2;
			last_s3 <= last_s2;
		end
	end

	// running sums including the item in the last stage
	always_comb begin
		sums_next.sum = acc_sum_q + {{(SUM_W-PROD_W){prod_s3[PROD_W-1]}}, prod_s3};
		sums_next.sq  = acc_sq_q + {{(SQ_W-SQW_W){1'b0}}, sqw_s3};
		sums_next.tw  = acc_tw_q + {{(TW_W-WEIGHT_W){1'b0}}, w_s3};
	end

	assign push      = adv && v_s3 && last_s3;
	assign push_data = sums_next;

	// accumulators clear as a finished set leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_sum_q <= '0;
			acc_sq_q  <= '0;
			acc_tw_q  <= '0;
		end else if (adv && v_s3) begin
			if (last_s3) begin
				acc_sum_q <= '0;
				acc_sq_q  <= '0;
				acc_tw_q  <= '0;
			end else begin
				acc_sum_q <= sums_next.sum;
				acc_sq_q  <= sums_next.sq;
				acc_tw_q  <= sums_next.tw;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wmv_queue.sv =====
// two-entry queue of finished set sums
`timescale 1ns / 1ps
`default_nettype none

module wmv_queue
	import wmv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire set_sums_t push_data,
	input  wire logic   pop,
	output set_sums_t   pop_data,
	output q_stat_t     q_stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	set_sums_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign q_stat.full      = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.not_empty = (cnt_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wmv_back.sv =====
// back end: divides set sums into mean and variance, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none

module wmv_back
	import wmv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire q_stat_t q_stat,
	input  wire set_sums_t pop_data,
	output logic        pop,
	wmv_out_if.source   results
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIV_MN = 5'b00010,
		ST_MEAN   = 5'b00100,
		ST_DIV_SQ = 5'b01000,
		ST_FINISH = 5'b10000
	} back_state_t;

	back_state_t state_q;

	logic [TW_W-1:0] tw_q;
	logic [SQ_W-1:0] sq_q;
	logic            neg_q;
	logic            zw_q;
	logic [SQ_W-1:0] dq_q;
	logic [TW_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic signed [MM_W-1:0] mm_q;

	logic [TW_W:0]  rem_sh;
	logic           ge;
	logic [TW_W:0]  rem_sub;
	logic [TW_W-1:0] rem_nx;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] quo;
	logic signed [MEAN_W-1:0] mean_sat;
	logic [SQ_W-1:0] mm_ext;
	logic [SQ_W-1:0] diff;
	logic [VAR_W-1:0] var_res;
	logic out_free;

	logic                     out_valid_q;
	logic signed [MEAN_W-1:0] out_mean_q;
	logic [VAR_W-1:0]         out_var_q;
	logic                     out_zw_q;

	// restoring divider step
	always_comb begin
		rem_sh  = {rem_q, dq_q[SQ_W-1]};
		ge      = (rem_sh >= {1'b0, tw_q});
		rem_sub = rem_sh - {1'b0, tw_q};
		rem_nx  = ge ? rem_sub[TW_W-1:0] : rem_sh[TW_W-1:0];
	end

	// magnitude of the signed sum
	assign mag = pop_data.sum[SUM_W-1] ? (~pop_data.sum + SUM_W'(1)) : pop_data.sum;

	// mean saturation to the signed 16-bit range
	always_comb begin
		quo = dq_q[SUM_W-1:0];
		if (neg_q) begin
			if (quo > SUM_W'(32768)) begin
				mean_sat = 16'sh8000;
			end else begin
				mean_sat = $signed(MEAN_W'(~quo + SUM_W'(1)));
			end
		end else begin
			if (quo > SUM_W'(32767)) begin
				mean_sat = 16'sh7fff;
			end else begin
				mean_sat = $signed(quo[MEAN_W-1:0]);
			end
		end
	end

	// mean of squares minus squared mean, clamped
	always_comb begin
		mm_ext = {{(SQ_W-MM_W){1'b0}}, mm_q};
		diff   = dq_q - mm_ext;
		if (dq_q <= mm_ext) begin
			var_res = '0;
		end else if (diff > {{(SQ_W-VAR_W){1'b0}}, VAR_MAX}) begin
			var_res = VAR_MAX;
		end else begin
			var_res = diff[VAR_W-1:0];
		end
	end

	assign out_free = !out_valid_q || results.ready;
	assign pop = (state_q == ST_IDLE) && q_stat.not_empty;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						state_q <= (pop_data.tw == '0) ? ST_FINISH : ST_DIV_MN;
					end
				end
				ST_DIV_MN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MEAN_STEPS - 1)) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					cnt_q   <= '0;
					state_q <= ST_DIV_SQ;
				end
				ST_DIV_SQ: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					tw_q  <= pop_data.tw;
					sq_q  <= pop_data.sq;
					neg_q <= pop_data.sum[SUM_W-1];
					zw_q  <= (pop_data.tw == '0);
					dq_q  <= {mag, {(SQ_W-SUM_W){1'b0}}};
					rem_q <= '0;
				end
			end
			ST_DIV_MN: begin
				dq_q  <= {dq_q[SQ_W-2:0], ge};
				rem_q <= rem_nx;
			end
			ST_MEAN: begin
				mean_q <= mean_sat;
				dq_q   <= sq_q;
				rem_q  <= '0;
			end
			ST_DIV_SQ: begin
				dq_q  <= {dq_q[SQ_W-2:0], ge};
				rem_q <= rem_nx;
				mm_q  <= mean_q * mean_q;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_zw_q   <= zw_q;
			out_mean_q <= zw_q ? '0 : mean_q;
			out_var_q  <= zw_q ? '0 : var_res;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.mean        = out_mean_q;
	assign results.variance    = out_var_q;
	assign results.zero_weight = out_zw_q;

endmodule

`default_nettype wire

// ===== rtl/weighted_mean_variance.sv =====
// weighted mean and variance, top level
// throughput: one sample per cycle while input is not stalled; the back end's shared
// bit-serial divider takes 36 steps for the mean and 50 for the mean of squares per set
// a two-entry queue of set sums lets the front run ahead; with the queue full, a finished set stalls input
// reset: arst_n clears accumulators, queue, sequencer, output valid and weighted (to 0)
`timescale 1ns / 1ps
`default_nettype none

module weighted_mean_variance
	import wmv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	wmv_in_if.sink      samples,
	wmv_out_if.source   results
);

	logic      push;
	logic      pop;
	set_sums_t push_data;
	set_sums_t pop_data;
	q_stat_t   q_stat;

	// accumulation front end
	wmv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// set queue
	wmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// division back end
	wmv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.results  (results)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("set pushed into full queue");

	// input stalls only behind a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> q_stat.full)
		else $error("input stalled without a full queue");

	// zero-weight results carry zero values
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.zero_weight) |-> (results.mean == '0 && results.variance == '0))
		else $error("zero-weight transaction with nonzero values");

	// variance stays within its clamp
	a_var_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.variance <= VAR_MAX))
		else $error("variance above clamp");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire
